>>> hw/rtl/fed_pkg.sv
// Shared types and constants for the feedback echo delay block.
// No dependencies; used by fed_datapath and feedback_echo_delay.
`default_nettype none

package fed_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MULT,
    ST_WRITE
  } state_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_DELAY_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_FEEDBACK_GAIN = 2'd1;
  localparam logic [1:0] CFG_WET_MIX       = 2'd2;

  // Request function codes.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Fixed-point constants (gains are unsigned Q1.15).
  localparam int          GAIN_FRAC    = 15;
  localparam logic [15:0] GAIN_ONE     = 16'd32768;
  localparam logic [14:0] FEEDBACK_CAP = 15'd32440;

  // Register reset values.
  localparam logic [14:0] RESET_LENGTH = 15'd13230;
  localparam logic [14:0] RESET_FB     = 15'd13107;
  localparam logic [15:0] RESET_MIX    = 16'd13107;

endpackage

`default_nettype wire

>>> hw/rtl/fed_mem.sv
// Delay store: single write port, single read port, registered read data.
// No package dependencies.
`default_nettype none

module fed_mem #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 16,
  parameter int AW    = 14
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fed_datapath.sv
// Gain multipliers with a product register, then floor shift and saturation.
// Depends on fed_pkg for the gain constants.
`default_nettype none

module fed_datapath #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          mul_en,
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire logic signed [SAMPLE_BITS-1:0] d,
  input  wire logic        [14:0]            feedback_gain,
  input  wire logic        [15:0]            wet_mix,
  output logic signed      [SAMPLE_BITS-1:0] y,
  output logic signed      [SAMPLE_BITS-1:0] w
);

  localparam int PW = SAMPLE_BITS + 18;
  localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

  logic        [15:0]   mix_c;
  logic        [15:0]   dry_g;
  logic        [14:0]   fb_c;
  logic signed [PW-1:0] x_e;
  logic signed [PW-1:0] d_e;
  logic signed [PW-1:0] p_dry_r;
  logic signed [PW-1:0] p_wet_r;
  logic signed [PW-1:0] p_fb_r;
  logic signed [PW-1:0] mix_sum;
  logic signed [PW-1:0] fb_sum;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return SAMPLE_BITS'(c);
  endfunction

  assign mix_c = (wet_mix > fed_pkg::GAIN_ONE) ? fed_pkg::GAIN_ONE : wet_mix;
  assign dry_g = fed_pkg::GAIN_ONE - mix_c;
  assign fb_c  = (feedback_gain > fed_pkg::FEEDBACK_CAP) ? fed_pkg::FEEDBACK_CAP
                                                         : feedback_gain;
  assign x_e   = PW'(x);
  assign d_e   = PW'(d);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p_dry_r <= x_e * $signed(PW'(dry_g));
      p_wet_r <= d_e * $signed(PW'(mix_c));
      p_fb_r  <= d_e * $signed(PW'(fb_c));
    end
  end

  // Arithmetic right shift floors toward minus infinity.
  assign mix_sum = (p_dry_r + p_wet_r) >>> fed_pkg::GAIN_FRAC;
  assign fb_sum  = x_e + (p_fb_r >>> fed_pkg::GAIN_FRAC);
  assign y       = sat(mix_sum);
  assign w       = sat(fb_sum);

endmodule

`default_nettype wire

>>> hw/rtl/feedback_echo_delay.sv
// Top level of the feedback echo delay: controller, registers, write position.
// Depends on fed_pkg, fed_mem and fed_datapath.
`default_nettype none

// Usage
// The input channel (in_valid/in_ready) carries one request per item: in_func
// selects a sample request or a clear request, and in_sample_in holds the
// signed sample. Each sample request gives exactly one result on the output
// channel (out_valid/out_ready); a clear request gives none.
// A sample request runs in three steps: the delayed sample is read from the
// store on the accepting edge, the three gain products are registered in the
// multiply state, and in the write state the sum is saturated, written back to
// the store and loaded into the output register. The store's read-modify-write
// is not overlapped, so a new request is taken only once the previous one has
// been written back. The output register parts the two sides: the next
// request is accepted while a result still waits, and only the write-back step
// holds if the receiver is still stalling when the next result is ready.
// After reset, and after every clear request, the block sweeps the store and
// writes zero to each entry, one per cycle; no request is accepted during the
// sweep. Configuration writes are taken at any time and reset restores the
// default delay length and gains.
module feedback_echo_delay #(
  parameter int MAX_DELAY   = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] out_sample_out,
  input  wire logic                          cfg_we,
  input  wire logic        [1:0]             cfg_index,
  input  wire logic        [15:0]            cfg_wdata
);

  localparam int AW = $clog2(MAX_DELAY);
  // Wide enough for both the 15-bit length register and MAX_DELAY itself.
  localparam int LW = (AW >= 15) ? AW + 1 : 16;

  fed_pkg::state_t state_r, state_nxt;

  logic [14:0]                   delay_length_r;
  logic [14:0]                   feedback_gain_r;
  logic [15:0]                   wet_mix_r;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic                          in_fire;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [SAMPLE_BITS-1:0]        mem_wdata;
  logic [SAMPLE_BITS-1:0]        mem_rdata;
  logic                          mul_en;
  logic                          wb_en;
  logic signed [SAMPLE_BITS-1:0] dp_y;
  logic signed [SAMPLE_BITS-1:0] dp_w;
  logic [LW-1:0]                 len_ext;
  logic [LW-1:0]                 len_eff;
  logic [LW-1:0]                 pos_inc;
  logic [AW-1:0]                 pos_wrap;

  assign in_fire  = in_valid && in_ready;

  // Effective delay length: zero acts as one, anything above the store depth
  // acts as the full depth.
  assign len_ext = LW'(delay_length_r);
  always_comb begin
    if (len_ext == '0) begin
      len_eff = LW'(1);
    end else if (len_ext > LW'(MAX_DELAY)) begin
      len_eff = LW'(MAX_DELAY);
    end else begin
      len_eff = len_ext;
    end
  end

  // The position always stays below MAX_DELAY, so a shortened length only
  // makes the next advance wrap to zero.
  assign pos_inc  = LW'(pos_r) + LW'(1);
  assign pos_wrap = (pos_inc >= len_eff) ? '0 : AW'(pos_inc);

  // Controller: next state and strobes.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    mul_en        = 1'b0;
    wb_en         = 1'b0;
    case (state_r)
      fed_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_DELAY - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = fed_pkg::ST_IDLE;
        end
      end
      fed_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == fed_pkg::FUNC_CLEAR) begin
            pos_nxt      = '0;
            clr_addr_nxt = '0;
            state_nxt    = fed_pkg::ST_CLEAR;
          end else begin
            state_nxt = fed_pkg::ST_MULT;
          end
        end
      end
      fed_pkg::ST_MULT: begin
        mul_en    = 1'b1;
        state_nxt = fed_pkg::ST_WRITE;
      end
      fed_pkg::ST_WRITE: begin
        // Hold until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          wb_en         = 1'b1;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_wrap;
          state_nxt     = fed_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fed_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fed_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_length_r  <= fed_pkg::RESET_LENGTH;
      feedback_gain_r <= fed_pkg::RESET_FB;
      wet_mix_r       <= fed_pkg::RESET_MIX;
    end else if (cfg_we) begin
      case (cfg_index)
        fed_pkg::CFG_DELAY_LENGTH:  delay_length_r  <= cfg_wdata[14:0];
        fed_pkg::CFG_FEEDBACK_GAIN: feedback_gain_r <= cfg_wdata[14:0];
        fed_pkg::CFG_WET_MIX:       wet_mix_r       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_sample_in;
    end
    if (wb_en) begin
      out_data_r <= dp_y;
    end
  end

  // The sweep and the write-back share the single write port; they never
  // overlap because the sweep runs only in its own state.
  assign mem_we    = (state_r == fed_pkg::ST_CLEAR) || wb_en;
  assign mem_waddr = (state_r == fed_pkg::ST_CLEAR) ? clr_addr_r : pos_r;
  assign mem_wdata = (state_r == fed_pkg::ST_CLEAR) ? '0 : dp_w;

  fed_mem #(
    .DEPTH (MAX_DELAY),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (pos_r),
    .rdata (mem_rdata)
  );

  fed_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .mul_en        (mul_en),
    .x             (x_r),
    .d             ($signed(mem_rdata)),
    .feedback_gain (feedback_gain_r),
    .wet_mix       (wet_mix_r),
    .y             (dp_y),
    .w             (dp_w)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

`ifndef SYNTH
  a_sample_to_mult: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == fed_pkg::FUNC_SAMPLE) |=> (state_r == fed_pkg::ST_MULT))
    else $error("sample request did not start the multiply step");

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == fed_pkg::FUNC_CLEAR) |=>
      (state_r == fed_pkg::ST_CLEAR && clr_addr_r == '0 && pos_r == '0))
    else $error("clear request did not restart the sweep");

  a_writeback_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    wb_en |=> (out_valid_r && state_r == fed_pkg::ST_IDLE))
    else $error("write-back did not present a result");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fed_pkg::ST_CLEAR) |-> (!in_ready && !wb_en))
    else $error("request or write-back during the store sweep");
`endif

endmodule

`default_nettype wire
